// ===== sv/pscr_pkg.sv =====
// Shared types and constants of the periodic sine color remap block.
`default_nettype none

package pscr_pkg;

  // Width of one color component and of alpha.
  localparam int unsigned CompBits = 16;
  // Default address width of the quarter-wave sine table.
  localparam int unsigned SineAddrBitsDef = 10;
  // Angle accumulator width, in fractions of a turn.
  localparam int unsigned AccBits = CompBits + 8;
  localparam int unsigned FreqBits = 13;
  localparam int unsigned PhaseBits = 16;
  localparam int unsigned KeepBits = 3;
  // Register stages of one component lane, from accept to result.
  localparam int unsigned LaneStages = 6;

  localparam int unsigned CfgIdxBits = 3;
  localparam int unsigned CfgDataBits = 16;

  localparam logic [FreqBits-1:0] FreqReset = FreqBits'(256);
  localparam logic [PhaseBits-1:0] PhaseReset = '0;
  localparam logic [KeepBits-1:0] KeepReset = '0;

  typedef enum logic [CfgIdxBits-1:0] {
    CfgFreqFirst   = 3'd0,
    CfgFreqSecond  = 3'd1,
    CfgFreqThird   = 3'd2,
    CfgPhaseFirst  = 3'd3,
    CfgPhaseSecond = 3'd4,
    CfgPhaseThird  = 3'd5,
    CfgKeepMask    = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic [CompBits-1:0] comp_a_in;
    logic [CompBits-1:0] comp_b_in;
    logic [CompBits-1:0] comp_c_in;
    logic [CompBits-1:0] alpha_in;
    logic                run_end_in;
  } pscr_in_t;

  typedef struct packed {
    logic [CompBits-1:0] comp_a_out;
    logic [CompBits-1:0] comp_b_out;
    logic [CompBits-1:0] comp_c_out;
    logic [CompBits-1:0] alpha_out;
    logic                run_end_out;
  } pscr_out_t;

  // Words that bypass the lanes: alpha and the run end flag.
  typedef struct packed {
    logic [CompBits-1:0] alpha;
    logic                run_end;
  } pscr_side_t;

endpackage

`default_nettype wire

// ===== sv/pscr_lane.sv =====
// One component lane: angle, quarter-wave table lookup, interpolation, rounding.
`default_nettype none

module pscr_lane
  import pscr_pkg::*;
#(
  parameter int unsigned SINE_ADDR_BITS = SineAddrBitsDef
) (
  input  wire logic                 clk_i,
  input  wire logic [CompBits-1:0]  comp_i,
  input  wire logic [FreqBits-1:0]  freq_i,
  input  wire logic [PhaseBits-1:0] phase_i,
  input  wire logic                 keep_i,
  output logic      [CompBits-1:0]  result_o
);

  localparam int unsigned QuarterLen = 2 ** SINE_ADDR_BITS;
  localparam int unsigned FracBits = AccBits - SINE_ADDR_BITS - 2;
  localparam int unsigned IdxBits = SINE_ADDR_BITS + 1;
  localparam int unsigned PosBits = AccBits - 1;
  localparam int unsigned ProdBits = CompBits + FreqBits + 2;
  localparam int unsigned MulBits = 31 + FracBits + 1;
  localparam longint unsigned HalfPiQ30 = 64'd1686629713;
  localparam logic [31:0] OneQ30 = 32'h4000_0000;

  typedef logic [30:0] rom_t [QuarterLen+1];

  // sin(x) for x in Q30, one Taylor term at a time.
  function automatic longint unsigned tmul(longint unsigned t, longint unsigned x2);
    return (t * x2) >> 30;
  endfunction

  function automatic rom_t build_rom();
    rom_t r;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned t;
    longint s;
    for (int i = 0; i <= QuarterLen; i++) begin
      x = (HalfPiQ30 * longint'(i)) >> SINE_ADDR_BITS;
      x2 = (x * x) >> 30;
      t = x;
      s = longint'(x);
      t = tmul(t, x2) / 6;   s = s - longint'(t);
      t = tmul(t, x2) / 20;  s = s + longint'(t);
      t = tmul(t, x2) / 42;  s = s - longint'(t);
      t = tmul(t, x2) / 72;  s = s + longint'(t);
      t = tmul(t, x2) / 110; s = s - longint'(t);
      t = tmul(t, x2) / 156; s = s + longint'(t);
      t = tmul(t, x2) / 210; s = s - longint'(t);
      t = tmul(t, x2) / 272; s = s + longint'(t);
      t = tmul(t, x2) / 342; s = s - longint'(t);
      t = tmul(t, x2) / 420; s = s + longint'(t);
      if (s < 0) begin
        s = 0;
      end
      if (s > 64'sd1073741824) begin
        s = 64'sd1073741824;
      end
      r[i] = s[30:0];
    end
    return r;
  endfunction

  localparam rom_t SineRom = build_rom();

  // Stage 1: offset the component around one half and scale by frequency.
  logic signed [CompBits:0]   dlt;
  logic signed [ProdBits-1:0] prod_full;
  logic [AccBits-1:0]         prod_q;

  assign dlt = $signed({1'b0, comp_i}) - $signed((CompBits+1)'(2 ** (CompBits - 1)));
  assign prod_full = dlt * $signed({1'b0, freq_i});

  // Stage 2: add phase, fold the angle into the first quadrant.
  logic [AccBits-1:0] acc;
  logic [1:0]         quad;
  logic [PosBits-1:0] pos;
  logic [IdxBits-1:0] idx;
  logic [IdxBits-1:0] nxt;
  logic [IdxBits-1:0] idx_q, nxt_q;
  logic [FracBits-1:0] frac_q, frac3_q;
  logic               neg_q, neg3_q, neg4_q, neg5_q;

  assign acc = prod_q + {phase_i, {(AccBits - PhaseBits){1'b0}}};
  assign quad = acc[AccBits-1 -: 2];

  always_comb begin
    if (quad[0]) begin
      pos = PosBits'(2 ** (AccBits - 2)) - {1'b0, acc[AccBits-3:0]};
    end else begin
      pos = {1'b0, acc[AccBits-3:0]};
    end
  end

  assign idx = pos[PosBits-1:FracBits];
  // At the top of the table the next entry is the same entry.
  assign nxt = (idx < IdxBits'(QuarterLen)) ? idx + 1'b1 : idx;

  // Stage 3: table reads.
  logic [30:0] rom0_q, rom1_q;

  // Stage 4: interpolation weights.
  logic [FracBits:0]  wlo;
  logic [MulBits-1:0] p0_q, p1_q;

  assign wlo = (FracBits+1)'(2 ** FracBits) - {1'b0, frac3_q};

  // Stage 5: interpolated magnitude.
  logic [MulBits:0] psum;
  logic [30:0]      mag_q;

  assign psum = {1'b0, p0_q} + {1'b0, p1_q};

  // Stage 6: center on one half, round, saturate, or keep the delayed input.
  logic [31:0]         vq;
  logic [31:0]         vr;
  logic [CompBits:0]   yq;
  logic [CompBits-1:0] ysat;
  logic [CompBits-1:0] xd_q [LaneStages-1];
  logic [CompBits-1:0] res_q;

  always_comb begin
    if (neg5_q) begin
      vq = OneQ30 - {1'b0, mag_q};
    end else begin
      vq = OneQ30 + {1'b0, mag_q};
    end
  end

  assign vr = vq + 32'(2 ** (30 - CompBits));
  assign yq = vr[31 -: (CompBits + 1)];
  assign ysat = yq[CompBits] ? {CompBits{1'b1}} : yq[CompBits-1:0];

  always_ff @(posedge clk_i) begin
    prod_q  <= prod_full[AccBits-1:0];
    idx_q   <= idx;
    nxt_q   <= nxt;
    frac_q  <= pos[FracBits-1:0];
    neg_q   <= quad[1];
    rom0_q  <= SineRom[idx_q];
    rom1_q  <= SineRom[nxt_q];
    frac3_q <= frac_q;
    neg3_q  <= neg_q;
    p0_q    <= MulBits'(rom0_q) * MulBits'(wlo);
    p1_q    <= MulBits'(rom1_q) * MulBits'(frac3_q);
    neg4_q  <= neg3_q;
    mag_q   <= psum[FracBits +: 31];
    neg5_q  <= neg4_q;
    res_q   <= keep_i ? xd_q[LaneStages-2] : ysat;
    xd_q[0] <= comp_i;
    for (int s = 1; s < LaneStages - 1; s++) begin
      xd_q[s] <= xd_q[s-1];
    end
  end

  assign result_o = res_q;

endmodule

`default_nettype wire

// ===== sv/periodic_sine_color_remap_top.sv =====
// Top level of the periodic sine color remap block.
//
// A pixel word is taken at a rising edge with start high and busy low.
// busy stays low, so a new pixel may be issued in every cycle.
// Each of the three color components runs through its own lane: scale by
// frequency and add phase, fold into one quadrant, read two neighboring
// entries of a quarter-wave sine table, interpolate, round and saturate.
// Alpha and the run end flag travel alongside in a delay line.
// A result word appears on res_o for one cycle with res_valid_o high,
// once its pixel has passed the lane stages; one result per pixel, in order.
// Throughput is one pixel per clock; the multiplier stages and the
// registered table read set the latency.
// The receiver cannot hold results off: a result is taken in the cycle
// its strobe is high.
// Configuration words arrive on the cfg channel (cfg_ready_o is always
// high) and should be written only while no pixel is in flight.
// Reset clears the pipeline valid bits and loads frequency 1.0, phase zero
// and an empty keep mask into the registers.
`default_nettype none

module periodic_sine_color_remap_top
  import pscr_pkg::*;
#(
  parameter int unsigned SINE_ADDR_BITS = SineAddrBitsDef
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   start,
  output logic                        busy,
  input  wire pscr_in_t               in_i,
  output logic                        res_valid_o,
  output pscr_out_t                   res_o,
  input  wire logic                   cfg_valid_i,
  output logic                        cfg_ready_o,
  input  wire logic [CfgIdxBits-1:0]  cfg_index_i,
  input  wire logic [CfgDataBits-1:0] cfg_data_i
);

  logic accept;
  logic cfg_we;

  assign busy = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign accept = start & ~busy;
  assign cfg_we = cfg_valid_i & cfg_ready_o;

  // Configuration registers.
  logic [FreqBits-1:0]  freq_q  [3];
  logic [FreqBits-1:0]  freq_d  [3];
  logic [PhaseBits-1:0] phase_q [3];
  logic [PhaseBits-1:0] phase_d [3];
  logic [KeepBits-1:0]  keep_q, keep_d;

  always_comb begin
    freq_d  = freq_q;
    phase_d = phase_q;
    keep_d  = keep_q;
    if (cfg_we) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CfgFreqFirst:   freq_d[0]  = cfg_data_i[FreqBits-1:0];
        CfgFreqSecond:  freq_d[1]  = cfg_data_i[FreqBits-1:0];
        CfgFreqThird:   freq_d[2]  = cfg_data_i[FreqBits-1:0];
        CfgPhaseFirst:  phase_d[0] = cfg_data_i[PhaseBits-1:0];
        CfgPhaseSecond: phase_d[1] = cfg_data_i[PhaseBits-1:0];
        CfgPhaseThird:  phase_d[2] = cfg_data_i[PhaseBits-1:0];
        CfgKeepMask:    keep_d     = cfg_data_i[KeepBits-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        freq_q[i]  <= FreqReset;
        phase_q[i] <= PhaseReset;
      end
      keep_q <= KeepReset;
    end else begin
      freq_q  <= freq_d;
      phase_q <= phase_d;
      keep_q  <= keep_d;
    end
  end

  // Valid bits travel alongside the lane stages.
  logic [LaneStages-1:0] vld_q, vld_d;

  assign vld_d = {vld_q[LaneStages-2:0], accept};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // Alpha and run end delay line.
  pscr_side_t side_q [LaneStages];

  always_ff @(posedge clk_i) begin
    side_q[0] <= '{alpha: in_i.alpha_in, run_end: in_i.run_end_in};
    for (int s = 1; s < LaneStages; s++) begin
      side_q[s] <= side_q[s-1];
    end
  end

  logic [CompBits-1:0] lane_in  [3];
  logic [CompBits-1:0] lane_out [3];

  assign lane_in[0] = in_i.comp_a_in;
  assign lane_in[1] = in_i.comp_b_in;
  assign lane_in[2] = in_i.comp_c_in;

  for (genvar g = 0; g < 3; g++) begin : g_lane
    pscr_lane #(
      .SINE_ADDR_BITS(SINE_ADDR_BITS)
    ) u_lane (
      .clk_i   (clk_i),
      .comp_i  (lane_in[g]),
      .freq_i  (freq_q[g]),
      .phase_i (phase_q[g]),
      .keep_i  (keep_q[g]),
      .result_o(lane_out[g])
    );
  end

  assign res_valid_o       = vld_q[LaneStages-1];
  assign res_o.comp_a_out  = lane_out[0];
  assign res_o.comp_b_out  = lane_out[1];
  assign res_o.comp_c_out  = lane_out[2];
  assign res_o.alpha_out   = side_q[LaneStages-1].alpha;
  assign res_o.run_end_out = side_q[LaneStages-1].run_end;

endmodule

`default_nettype wire
